>>> src/inst_freq_demod_smoother_core_assert.svh
// Assertion macros used by the demodulator back end.
// Needs clk and rst in the scope where a macro is used.
`ifndef INST_FREQ_DEMOD_SMOOTHER_CORE_ASSERT_SVH
`define INST_FREQ_DEMOD_SMOOTHER_CORE_ASSERT_SVH

// Condition holds at every clock edge out of reset
`define IFD_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define IFD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent
`define IFD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ifd_pkg.sv
// Shared types, constants and tables of the instantaneous frequency demodulator.
// No dependencies.
package ifd_pkg;

  localparam int PHASE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int WORK_W            = 44;

  localparam logic [19:0] INV_GAIN = 20'd636752;
  localparam logic [32:0] AMP_MAX  = 33'h1_FFFF_FFFF;

  localparam logic [14:0] W_EDGE   = 15'd4430;
  localparam logic [14:0] W_NEAR   = 15'd16422;
  localparam logic [14:0] W_CENTRE = 15'd23832;

  typedef enum logic [1:0] {
    REG_BASELINE_X = 2'd0,
    REG_BASELINE_Y = 2'd1,
    REG_SAMPLE_RATE = 2'd2,
    REG_SKIP_COUNT = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    F_IDLE, F_PRE, F_ROT, F_MLO, F_MHI, F_SUM, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MULT, B_UPDATE, B_SEL, B_MAC, B_EMIT
  } back_state_t;

  // Per-item information passed from front to back
  typedef struct packed {
    logic        end_only;
    logic        last;
    logic [32:0] mag;
  } q_info_t;

  // Arctangent of 2^-i as a 32 bit binary angle
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // Smoother weight for one tap
  function automatic logic [14:0] tap_weight(input logic [2:0] tap);
    logic [14:0] w;
    case (tap)
      3'd0, 3'd4: w = W_EDGE;
      3'd1, 3'd3: w = W_NEAR;
      3'd2:       w = W_CENTRE;
      default:    w = 15'd0;
    endcase
    return w;
  endfunction

endpackage

>>> src/ifd_front.sv
// Front end: takes items, drops leading samples, runs the iterative CORDIC
// and the split magnitude scaling. Depends on ifd_pkg.
module ifd_front import ifd_pkg::*; #(
  parameter int PHASE_BITS    = PHASE_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           x_sample,
  input  logic [31:0]           y_sample,
  input  logic                  last_in_trace,
  input  logic [31:0]           baseline_x,
  input  logic [31:0]           baseline_y,
  input  logic [7:0]            skip_count,
  output logic                  push_valid,
  input  logic                  push_ready,
  output q_info_t               push_info,
  output logic [PHASE_BITS-1:0] push_phase
);

  localparam int IDX_W = $clog2(CORDIC_STAGES);

  front_state_t state, state_next;
  logic [7:0]  skip_counter;
  logic signed [32:0] xs, ys;
  logic signed [WORK_W-1:0] re, im;
  logic [31:0] z;
  logic [IDX_W-1:0] idx;
  logic        zero_vec, last_r, end_only_r;
  logic [41:0] plo, phi;
  logic [32:0] mag;
  logic [PHASE_BITS-1:0] phase;

  logic signed [WORK_W-1:0] re_s, im_s, re_sh, im_sh;
  logic [WORK_W-1:0] mpos;
  logic [63:0] mtotal;
  logic [35:0] mround;
  logic [32:0] zsum;
  logic        accept, skipping;

  assign accept   = in_valid && in_ready;
  assign skipping = skip_counter < skip_count;
  assign re_s  = $signed({{3{ys[32]}}, ys, 8'b0});
  assign im_s  = $signed({{3{xs[32]}}, xs, 8'b0});
  assign re_sh = re >>> idx;
  assign im_sh = im >>> idx;
  assign mpos  = re[WORK_W-1] ? '0 : re;
  assign mtotal = {phi, 22'b0} + {22'b0, plo} + (64'd1 << 27);
  assign mround = mtotal[63:28];
  assign zsum   = {1'b0, z} + (33'd1 << (31 - PHASE_BITS));

  assign push_info  = '{end_only: end_only_r, last: last_r, mag: mag};
  assign push_phase = phase;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    push_valid = 1'b0;
    case (state)
      F_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (!skipping) begin
            state_next = F_PRE;
          end else if (last_in_trace) begin
            state_next = F_PUSH;
          end
        end
      end
      F_PRE: state_next = F_ROT;
      F_ROT: begin
        if (idx == IDX_W'(CORDIC_STAGES - 1)) begin
          state_next = F_MLO;
        end
      end
      F_MLO: state_next = F_MHI;
      F_MHI: state_next = F_SUM;
      F_SUM: state_next = F_PUSH;
      F_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // Skip counter: advance while dropping, clear at the end of a trace
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_counter <= '0;
    end else if (accept) begin
      if (last_in_trace) begin
        skip_counter <= '0;
      end else if (skipping) begin
        skip_counter <= skip_counter + 8'd1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (accept) begin
          last_r     <= last_in_trace;
          end_only_r <= skipping;
          mag        <= '0;
          phase      <= '0;
          xs <= $signed({x_sample[31], x_sample}) - $signed({baseline_x[31], baseline_x});
          ys <= $signed({y_sample[31], y_sample}) - $signed({baseline_y[31], baseline_y});
        end
      end
      F_PRE: begin
        zero_vec <= (xs == '0) && (ys == '0);
        idx      <= '0;
        if (ys[32]) begin
          re <= -re_s;
          im <= -im_s;
          z  <= 32'h8000_0000;
        end else begin
          re <= re_s;
          im <= im_s;
          z  <= '0;
        end
      end
      F_ROT: begin
        idx <= idx + IDX_W'(1);
        if (!im[WORK_W-1]) begin
          re <= re + im_sh;
          im <= im - re_sh;
          z  <= z + atan_entry(5'(idx));
        end else begin
          re <= re - im_sh;
          im <= im + re_sh;
          z  <= z - atan_entry(5'(idx));
        end
      end
      F_MLO: plo <= mpos[21:0] * INV_GAIN;
      F_MHI: phi <= mpos[43:22] * INV_GAIN;
      F_SUM: begin
        if (zero_vec) begin
          mag   <= '0;
          phase <= '0;
        end else begin
          mag   <= (mround > {3'b0, AMP_MAX}) ? AMP_MAX : mround[32:0];
          phase <= zsum[31:32-PHASE_BITS];
        end
      end
      default: ;
    endcase
  end

endmodule

>>> src/ifd_queue.sv
// Two-entry queue between the front and back ends.
// Depends on nothing but its width parameter.
module ifd_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store pushed items
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

>>> src/ifd_back.sv
// Back end: phase step to frequency, 5-tap smoother and result register.
// Depends on ifd_pkg and the assertion macro header.
`include "inst_freq_demod_smoother_core_assert.svh"
module ifd_back import ifd_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  q_info_t               q_info,
  input  logic [PHASE_BITS-1:0] q_phase,
  input  logic [23:0]           sample_rate_hz,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [71:0]           out_tdata,
  output logic                  out_tlast
);

  localparam int PROD_W = PHASE_BITS + 25;
  localparam int FS_W   = PROD_W + 8;
  localparam logic signed [FS_W-1:0] HALF = FS_W'(1) <<< (PHASE_BITS - 1);

  back_state_t state, state_next;
  logic [PHASE_BITS-1:0] prev_phase;
  logic [2:0] fill_count;
  logic signed [31:0] freq_window [5];
  logic [32:0] amp_delay [3];
  logic signed [PHASE_BITS-1:0] d;
  logic signed [PROD_W-1:0] prod;
  logic [32:0] mag_r;
  logic last_r, end_r, e2, e1, e0;
  logic [1:0] r;
  logic [2:0] tap;
  logic signed [49:0] acc;

  logic signed [FS_W-1:0] fsum, fsh;
  logic signed [31:0] f;
  logic [2:0] fill_next, v;
  logic signed [3:0] jr;
  logic [2:0] jc;
  logic signed [47:0] mac_prod;
  logic signed [49:0] ysum, ysh;
  logic signed [31:0] ysat;
  logic out_load, pop_end;

  assign fsum = $signed({prod, 8'b0}) + HALF;
  assign fsh  = fsum >>> PHASE_BITS;
  assign f    = fsh[31:0];
  assign fill_next = (fill_count == 3'd0) ? 3'd1 :
                     (fill_count < 3'd4) ? fill_count + 3'd1 : 3'd4;
  assign v = fill_next - 3'd1;

  // Window index for this tap, replicated at both edges
  assign jr = $signed({2'b0, r}) + 4'sd2 - $signed({1'b0, tap});
  assign jc = jr < 4'sd0 ? 3'd0 : (jr > 4'sd4 ? 3'd4 : jr[2:0]);
  assign mac_prod = $signed({1'b0, tap_weight(tap)}) * freq_window[3'd4 - jc];

  // Round and saturate the weighted sum
  assign ysum = acc + 50'sd32768;
  assign ysh  = ysum >>> 16;
  assign ysat = (ysh > 50'sd2147483647) ? 32'sh7FFF_FFFF :
                (ysh < -50'sd2147483648) ? 32'sh8000_0000 : ysh[31:0];

  assign q_ready  = state == B_IDLE;
  assign pop_end  = q_ready && q_valid && q_info.end_only;
  assign out_load = (state == B_EMIT) && (!out_tvalid || out_tready);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:   if (q_valid && !q_info.end_only) state_next = B_MULT;
      B_MULT:   state_next = B_UPDATE;
      B_UPDATE: state_next = B_SEL;
      B_SEL:    state_next = (e2 || e1 || e0) ? B_MAC : B_IDLE;
      B_MAC:    if (tap == 3'd4) state_next = B_EMIT;
      B_EMIT:   if (out_load) state_next = B_SEL;
      default:  state_next = B_IDLE;
    endcase
  end

  // Trace control state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_phase <= '0;
      fill_count <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            prev_phase <= q_info.end_only ? '0 : q_phase;
            if (q_info.end_only) fill_count <= '0;
          end
        end
        B_UPDATE: fill_count <= fill_next;
        B_SEL: begin
          if (!(e2 || e1 || e0) && last_r) begin
            fill_count <= '0;
            prev_phase <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Frequency, window, smoother datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        d      <= $signed(q_phase - prev_phase);
        mag_r  <= q_info.mag;
        last_r <= q_info.last;
      end
      B_MULT: prod <= d * $signed({1'b0, sample_rate_hz});
      B_UPDATE: begin
        if (fill_count != 3'd0) begin
          if (fill_count == 3'd1) begin
            for (int i = 0; i < 5; i++) freq_window[i] <= f;
          end else begin
            for (int i = 0; i < 4; i++) freq_window[i] <= freq_window[i+1];
            freq_window[4] <= f;
          end
          amp_delay[2] <= amp_delay[1];
          amp_delay[1] <= amp_delay[0];
          amp_delay[0] <= mag_r;
        end
        e2 <= v >= 3'd3;
        e1 <= last_r && (v >= 3'd2);
        e0 <= last_r && (v >= 3'd1);
      end
      B_SEL: begin
        acc <= '0;
        tap <= '0;
        if (e2) begin
          r <= 2'd2; e2 <= 1'b0; end_r <= 1'b0;
        end else if (e1) begin
          r <= 2'd1; e1 <= 1'b0; end_r <= 1'b0;
        end else if (e0) begin
          r <= 2'd0; e0 <= 1'b0; end_r <= 1'b1;
        end
      end
      B_MAC: begin
        acc <= acc + 50'(mac_prod);
        tap <= tap + 3'd1;
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (out_load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata <= {7'b0, amp_delay[r], ysat};
      out_tlast <= end_r;
    end
  end

  `IFD_ASSERT_NOW(a_fill_range, fill_count <= 3'd4, "fill count beyond four")
  `IFD_ASSERT_IMP(a_load_free, out_load, !out_tvalid || out_tready, "result overwritten")
  `IFD_ASSERT_NXT(a_end_clears, pop_end, fill_count == 3'd0 && prev_phase == '0,
                  "trace end did not clear state")

endmodule

>>> src/inst_freq_demod_smoother_core.sv
// Top level of the instantaneous frequency demodulator with 5-tap smoother.
// Depends on ifd_pkg, ifd_front, ifd_queue and ifd_back.
//
// Usage:
//  s_* takes complex samples: s_tdata holds x_sample and y_sample, s_tlast
//  marks the last sample of a trace. m_* gives results: m_tdata holds
//  freq_hz_q8 and amplitude, m_tlast marks the final result of a trace.
//  The APB port writes and reads baseline_x, baseline_y, sample_rate_hz and
//  skip_count at byte addresses 0, 4, 8 and 12; write only while idle.
//  Flow: a dropped leading sample is taken in F_IDLE and skips the CORDIC; a
//  processed sample holds the front end through F_PRE, F_ROT, F_MLO, F_MHI,
//  F_SUM and F_PUSH, which run the single shared CORDIC rotation stage and the
//  split magnitude multiply, and no new sample is taken until it is pushed.
//  The back end steps each point through B_MULT and B_UPDATE and each result
//  through B_MAC and B_EMIT on the single smoother multiply-accumulate; a
//  two-entry queue decouples the two. The result for a point leaves when the
//  point two later arrives, or at the trace's last sample.
//  Reset clears trace state and the registers; the smoother window and the
//  amplitude line are refilled at the start of every trace.
//  When the receiver stalls, the result register holds, the back end and
//  then the queue fill, and s_tready stays low until space frees.
module inst_freq_demod_smoother_core import ifd_pkg::*; #(
  parameter int PHASE_BITS    = PHASE_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] x_sample, [63:32] y_sample
  input  logic        s_tlast,   // last_in_trace
  // Result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [31:0] freq_hz_q8, [64:32] amplitude, zero fill
  output logic        m_tlast,   // trace_end
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int QW = $bits(q_info_t) + PHASE_BITS;

  logic [31:0] baseline_x, baseline_y;
  logic [23:0] sample_rate_hz;
  logic [7:0]  skip_count;
  cfg_reg_t    reg_sel;
  logic        cfg_write;

  logic                  push_valid, push_ready, pop_valid, pop_ready;
  q_info_t               push_info, pop_info;
  logic [PHASE_BITS-1:0] push_phase, pop_phase;
  logic [QW-1:0]         pop_data;

  assign pready    = 1'b1;
  assign reg_sel   = cfg_reg_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_x     <= '0;
      baseline_y     <= '0;
      sample_rate_hz <= 24'd1;
      skip_count     <= '0;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_BASELINE_X:  baseline_x     <= pwdata;
        REG_BASELINE_Y:  baseline_y     <= pwdata;
        REG_SAMPLE_RATE: sample_rate_hz <= pwdata[23:0];
        REG_SKIP_COUNT:  skip_count     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_sel)
      REG_BASELINE_X:  prdata = baseline_x;
      REG_BASELINE_Y:  prdata = baseline_y;
      REG_SAMPLE_RATE: prdata = {8'b0, sample_rate_hz};
      REG_SKIP_COUNT:  prdata = {24'b0, skip_count};
      default:         prdata = '0;
    endcase
  end

  ifd_front #(
    .PHASE_BITS(PHASE_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .x_sample(s_tdata[31:0]), .y_sample(s_tdata[63:32]), .last_in_trace(s_tlast),
    .baseline_x(baseline_x), .baseline_y(baseline_y), .skip_count(skip_count),
    .push_valid(push_valid), .push_ready(push_ready),
    .push_info(push_info), .push_phase(push_phase)
  );

  ifd_queue #(.W(QW)) u_queue (
    .clk(clk), .rst(rst),
    .push_valid(push_valid), .push_ready(push_ready),
    .push_data({push_info, push_phase}),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
  );

  assign pop_info  = q_info_t'(pop_data[QW-1:PHASE_BITS]);
  assign pop_phase = pop_data[PHASE_BITS-1:0];

  ifd_back #(.PHASE_BITS(PHASE_BITS)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(pop_valid), .q_ready(pop_ready),
    .q_info(pop_info), .q_phase(pop_phase),
    .sample_rate_hz(sample_rate_hz),
    .out_tvalid(m_tvalid), .out_tready(m_tready),
    .out_tdata(m_tdata), .out_tlast(m_tlast)
  );

endmodule
